// File: rtl/icr_pkg.sv
// shared types and constants for the ink crop and rotate block
// used by icr_ctrl, icr_datapath and ink_crop_rotate_ccw; no dependencies
`timescale 1ns / 1ps

package icr_pkg;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CANVAS_HEIGHT = 2'd1;

  // configuration register widths and reset values
  localparam int CanvasWidthW  = 9;
  localparam int CanvasHeightW = 7;
  localparam logic [CanvasWidthW-1:0]  CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [CanvasHeightW-1:0] CANVAS_HEIGHT_RST = 7'd64;

  // item fields
  localparam int PixelW     = 16;
  localparam int RotWidthW  = 7;
  localparam int RotHeightW = 9;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic load;  // store one pixel and update the ink box
    logic read;  // issue one rotated readout access
  } cmd_t;

endpackage

// File: rtl/icr_ram.sv
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module icr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/icr_ctrl.sv
// controller state machine: accepts items and sequences the readout response
// depends on icr_pkg
`timescale 1ns / 1ps

module icr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          func_i,
  output icr_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          valid_o
);

  icr_pkg::ctrl_state_e state_q, state_d;
  logic                 accept;

  assign accept = start_i && (state_q == icr_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icr_pkg::ST_IDLE: begin
        if (accept && (func_i == icr_pkg::FUNC_READ)) begin
          state_d = icr_pkg::ST_RESP;
        end
      end
      icr_pkg::ST_RESP: begin
        state_d = icr_pkg::ST_IDLE;
      end
      default: state_d = icr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load = accept && (func_i == icr_pkg::FUNC_LOAD);
    cmd_o.read = accept && (func_i == icr_pkg::FUNC_READ);
    busy_o     = (state_q == icr_pkg::ST_RESP);
    valid_o    = (state_q == icr_pkg::ST_RESP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/icr_datapath.sv
// datapath: canvas registers, load position, ink box tracker, readout position,
// frame store and result registers; depends on icr_pkg and icr_ram
`timescale 1ns / 1ps

module icr_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  icr_pkg::cmd_t                        cmd_i,
  input  logic [icr_pkg::PixelW-1:0]           pixel_in_i,
  input  logic                                 first_pixel_i,
  input  logic                                 cfg_we_i,
  input  logic [icr_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [icr_pkg::CfgDataW-1:0]         cfg_data_i,
  output logic [icr_pkg::PixelW-1:0]           pixel_out_o,
  output logic [icr_pkg::RotWidthW-1:0]        rotated_width_o,
  output logic [icr_pkg::RotHeightW-1:0]       rotated_height_o,
  output logic                                 empty_res_o,
  output logic                                 out_last_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int WCmpW = (CW + 1 > icr_pkg::CanvasWidthW) ? CW + 1 : icr_pkg::CanvasWidthW;
  localparam int HCmpW = (RW + 1 > icr_pkg::CanvasHeightW) ? RW + 1 : icr_pkg::CanvasHeightW;
  localparam logic [CW-1:0] LeftRst = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] TopRst  = RW'(MAX_HEIGHT - 1);

  // control state
  logic [icr_pkg::CanvasWidthW-1:0]  canvas_width_q, canvas_width_d;
  logic [icr_pkg::CanvasHeightW-1:0] canvas_height_q, canvas_height_d;
  logic [CW-1:0] load_col_q, load_col_d;
  logic [RW-1:0] load_row_q, load_row_d;
  logic [CW-1:0] box_left_q, box_left_d, box_right_q, box_right_d;
  logic [RW-1:0] box_top_q, box_top_d, box_bottom_q, box_bottom_d;
  logic          ink_seen_q, ink_seen_d;
  logic [CW-1:0] read_row_q, read_row_d;
  logic [RW-1:0] read_col_q, read_col_d;

  // result payload
  logic                              empty_q, last_q;
  logic [icr_pkg::RotWidthW-1:0]     rot_w_q;
  logic [icr_pkg::RotHeightW-1:0]    rot_h_q;
  logic [icr_pkg::PixelW-1:0]        ram_rdata;

  // effective canvas size
  logic [WCmpW-1:0] width_ext;
  logic [HCmpW-1:0] height_ext;
  logic [CW:0]      w_eff;
  logic [RW:0]      h_eff;

  // load path
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic          ink;
  logic          seen_cur;

  // read path
  logic [CW:0]   bw;
  logic [RW:0]   bh;
  logic          wrap;
  logic [CW-1:0] rr;
  logic [RW-1:0] rc;
  logic [CW-1:0] src_col;
  logic [RW-1:0] src_row;
  logic          row_end, col_end;
  logic          rd_issue;

  // ram port
  logic          ram_en;
  logic [AW-1:0] ram_addr;

  assign width_ext  = WCmpW'(canvas_width_q);
  assign height_ext = HCmpW'(canvas_height_q);

  always_comb begin
    priority if (width_ext == '0) begin
      w_eff = (CW + 1)'(1);
    end else if (width_ext > WCmpW'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(width_ext);
    end
    priority if (height_ext == '0) begin
      h_eff = (RW + 1)'(1);
    end else if (height_ext > HCmpW'(MAX_HEIGHT)) begin
      h_eff = (RW + 1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW + 1)'(height_ext);
    end
  end

  assign col_cur  = first_pixel_i ? '0 : load_col_q;
  assign row_cur  = first_pixel_i ? '0 : load_row_q;
  assign ink      = (pixel_in_i != '0);
  assign seen_cur = ink_seen_q && !first_pixel_i;

  // readout position, restarted when it falls outside the current box
  assign bw      = (CW + 1)'(box_right_q - box_left_q) + (CW + 1)'(1);
  assign bh      = (RW + 1)'(box_bottom_q - box_top_q) + (RW + 1)'(1);
  assign wrap    = ((CW + 1)'(read_row_q) >= bw) || ((RW + 1)'(read_col_q) >= bh);
  assign rr      = wrap ? '0 : read_row_q;
  assign rc      = wrap ? '0 : read_col_q;
  assign src_col = box_right_q - rr;
  assign src_row = box_top_q + rc;
  assign row_end = ((CW + 1)'(rr) + (CW + 1)'(1)) >= bw;
  assign col_end = ((RW + 1)'(rc) + (RW + 1)'(1)) >= bh;

  assign rd_issue = cmd_i.read && ink_seen_q;

  always_comb begin
    canvas_width_d  = canvas_width_q;
    canvas_height_d = canvas_height_q;
    if (cfg_we_i) begin
      if (cfg_index_i == icr_pkg::CFG_CANVAS_WIDTH) begin
        canvas_width_d = cfg_data_i[icr_pkg::CanvasWidthW-1:0];
      end
      if (cfg_index_i == icr_pkg::CFG_CANVAS_HEIGHT) begin
        canvas_height_d = cfg_data_i[icr_pkg::CanvasHeightW-1:0];
      end
    end
  end

  always_comb begin
    load_col_d   = load_col_q;
    load_row_d   = load_row_q;
    box_left_d   = box_left_q;
    box_right_d  = box_right_q;
    box_top_d    = box_top_q;
    box_bottom_d = box_bottom_q;
    ink_seen_d   = ink_seen_q;
    read_row_d   = read_row_q;
    read_col_d   = read_col_q;

    if (cmd_i.load) begin
      if (first_pixel_i) begin
        read_row_d   = '0;
        read_col_d   = '0;
        box_left_d   = LeftRst;
        box_right_d  = '0;
        box_top_d    = TopRst;
        box_bottom_d = '0;
        ink_seen_d   = 1'b0;
      end
      if (ink) begin
        ink_seen_d = 1'b1;
        if (!seen_cur) begin
          box_left_d   = col_cur;
          box_right_d  = col_cur;
          box_top_d    = row_cur;
          box_bottom_d = row_cur;
        end else begin
          if (col_cur < box_left_q)   box_left_d   = col_cur;
          if (col_cur > box_right_q)  box_right_d  = col_cur;
          if (row_cur < box_top_q)    box_top_d    = row_cur;
          if (row_cur > box_bottom_q) box_bottom_d = row_cur;
        end
      end
      // raster advance with wrap at the canvas edges
      if (((CW + 1)'(col_cur) + (CW + 1)'(1)) >= w_eff) begin
        load_col_d = '0;
        if (((RW + 1)'(row_cur) + (RW + 1)'(1)) >= h_eff) begin
          load_row_d = '0;
        end else begin
          load_row_d = row_cur + RW'(1);
        end
      end else begin
        load_col_d = col_cur + CW'(1);
        load_row_d = row_cur;
      end
    end

    if (rd_issue) begin
      if (col_end) begin
        read_col_d = '0;
        read_row_d = row_end ? '0 : rr + CW'(1);
      end else begin
        read_col_d = rc + RW'(1);
        read_row_d = rr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= icr_pkg::CANVAS_WIDTH_RST;
      canvas_height_q <= icr_pkg::CANVAS_HEIGHT_RST;
      load_col_q      <= '0;
      load_row_q      <= '0;
      box_left_q      <= LeftRst;
      box_right_q     <= '0;
      box_top_q       <= TopRst;
      box_bottom_q    <= '0;
      ink_seen_q      <= 1'b0;
      read_row_q      <= '0;
      read_col_q      <= '0;
    end else begin
      canvas_width_q  <= canvas_width_d;
      canvas_height_q <= canvas_height_d;
      load_col_q      <= load_col_d;
      load_row_q      <= load_row_d;
      box_left_q      <= box_left_d;
      box_right_q     <= box_right_d;
      box_top_q       <= box_top_d;
      box_bottom_q    <= box_bottom_d;
      ink_seen_q      <= ink_seen_d;
      read_row_q      <= read_row_d;
      read_col_q      <= read_col_d;
    end
  end

  // result fields are captured with the read access and shown in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      empty_q <= !ink_seen_q;
      last_q  <= ink_seen_q ? (row_end && col_end) : 1'b1;
      rot_w_q <= ink_seen_q ? icr_pkg::RotWidthW'(bh) : '0;
      rot_h_q <= ink_seen_q ? icr_pkg::RotHeightW'(bw) : '0;
    end
  end

  assign ram_en   = cmd_i.load || rd_issue;
  assign ram_addr = cmd_i.load ? {row_cur, col_cur} : {src_row, src_col};

  icr_ram #(
    .WIDTH (icr_pkg::PixelW),
    .DEPTH (1 << AW)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (cmd_i.load),
    .addr_i  (ram_addr),
    .wdata_i (pixel_in_i),
    .rdata_o (ram_rdata)
  );

  assign pixel_out_o      = empty_q ? '0 : ram_rdata;
  assign rotated_width_o  = rot_w_q;
  assign rotated_height_o = rot_h_q;
  assign empty_res_o      = empty_q;
  assign out_last_o       = last_q;

endmodule

// File: rtl/ink_crop_rotate_ccw.sv
// ink box crop and 90 degree counter-clockwise rotation, top level
// load: busy stays low, next item may follow in the next cycle
// read: result strobed on valid_o in the cycle after acceptance, busy for that
//   cycle, so no new item is taken until the result is shown; set by the registered frame store read
// the receiver cannot stall; reset clears position and box registers, loads the canvas
//   registers with their reset values; the frame store is not cleared
`timescale 1ns / 1ps

module ink_crop_rotate_ccw #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func_i,
  input  logic [icr_pkg::PixelW-1:0]           pixel_in_i,
  input  logic                                 first_pixel_i,
  output logic                                 valid_o,
  output logic [icr_pkg::PixelW-1:0]           pixel_out_o,
  output logic [icr_pkg::RotWidthW-1:0]        rotated_width_o,
  output logic [icr_pkg::RotHeightW-1:0]       rotated_height_o,
  output logic                                 empty_res_o,
  output logic                                 out_last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [icr_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [icr_pkg::CfgDataW-1:0]         cfg_data_i
);

  icr_pkg::cmd_t cmd;
  logic          cfg_we;

  // config registers take a transfer in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  icr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (valid_o)
  );

  icr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .pixel_in_i       (pixel_in_i),
    .first_pixel_i    (first_pixel_i),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_out_o      (pixel_out_o),
    .rotated_width_o  (rotated_width_o),
    .rotated_height_o (rotated_height_o),
    .empty_res_o      (empty_res_o),
    .out_last_o       (out_last_o)
  );

endmodule

// File: sim/ink_crop_rotate_ccw_tb.sv
// testbench for ink_crop_rotate_ccw: loads canvases, reads back the rotated ink box
// and checks every result against an in-bench prediction; depends on icr_pkg
`timescale 1ns / 1ps

module ink_crop_rotate_ccw_tb;

  localparam int MAX_W = 256;
  localparam int MAX_H = 64;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;
  localparam logic [icr_pkg::CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [icr_pkg::CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [icr_pkg::PixelW-1:0]     pixel;
    logic [icr_pkg::RotWidthW-1:0]  rot_w;
    logic [icr_pkg::RotHeightW-1:0] rot_h;
    logic                           empty;
    logic                           last;
  } rot_pixel_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic                           func_i;
  logic [icr_pkg::PixelW-1:0]     pixel_in_i;
  logic                           first_pixel_i;
  logic                           valid_o;
  logic [icr_pkg::PixelW-1:0]     pixel_out_o;
  logic [icr_pkg::RotWidthW-1:0]  rotated_width_o;
  logic [icr_pkg::RotHeightW-1:0] rotated_height_o;
  logic                           empty_res_o;
  logic                           out_last_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [icr_pkg::CfgIdxW-1:0]    cfg_index_i;
  logic [icr_pkg::CfgDataW-1:0]   cfg_data_i;

  ink_crop_rotate_ccw #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .pixel_in_i      (pixel_in_i),
    .first_pixel_i   (first_pixel_i),
    .valid_o         (valid_o),
    .pixel_out_o     (pixel_out_o),
    .rotated_width_o (rotated_width_o),
    .rotated_height_o(rotated_height_o),
    .empty_res_o     (empty_res_o),
    .out_last_o      (out_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the block state
  logic [icr_pkg::PixelW-1:0] canvas_mem [0:MAX_W*MAX_H-1];
  bit                canvas_written [0:MAX_W*MAX_H-1];
  int unsigned       width_reg, height_reg;
  int unsigned       ld_col, ld_row, rd_row, rd_col;
  int unsigned       ink_left, ink_right, ink_top, ink_bottom;
  bit                ink_seen;

  rot_pixel_t  rotated_q[$];
  rot_pixel_t  want_px;
  int unsigned gap_pct;
  int unsigned items_sent, loads_sent, reads_sent, frames_sent, reg_writes;
  int unsigned pixels_checked, mismatch_cnt, fail_cnt, cycle_cnt;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_ink_box();
    ink_left = MAX_W - 1;
    ink_right = 0;
    ink_top = MAX_H - 1;
    ink_bottom = 0;
    ink_seen = 1'b0;
  endfunction

  function automatic void canvas_load(logic [icr_pkg::PixelW-1:0] px, logic first);
    int unsigned w, h, addr;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    if (first) begin
      ld_col = 0;
      ld_row = 0;
      rd_row = 0;
      rd_col = 0;
      clear_ink_box();
    end
    if (ld_col >= MAX_W) ld_col = 0;
    if (ld_row >= MAX_H) ld_row = 0;
    addr = ld_row * MAX_W + ld_col;
    canvas_mem[addr] = px;
    canvas_written[addr] = 1'b1;
    if (px != '0) begin
      if (!ink_seen) begin
        ink_left = ld_col;
        ink_right = ld_col;
        ink_top = ld_row;
        ink_bottom = ld_row;
        ink_seen = 1'b1;
      end else begin
        if (ld_col < ink_left) ink_left = ld_col;
        if (ld_col > ink_right) ink_right = ld_col;
        if (ld_row < ink_top) ink_top = ld_row;
        if (ld_row > ink_bottom) ink_bottom = ld_row;
      end
    end
    if (ld_col + 1 >= w) begin
      ld_col = 0;
      ld_row = (ld_row + 1 >= h) ? 0 : ld_row + 1;
    end else begin
      ld_col++;
    end
  endfunction

  function automatic rot_pixel_t rotate_read();
    rot_pixel_t  r;
    int unsigned bw, bh, src_col, src_row;
    r = '0;
    if (!ink_seen) begin
      r.empty = 1'b1;
      r.last = 1'b1;
      return r;
    end
    bw = ink_right - ink_left + 1;
    bh = ink_bottom - ink_top + 1;
    if (rd_row >= bw || rd_col >= bh) begin
      rd_row = 0;
      rd_col = 0;
    end
    // output row r is source column right - r, walked top to bottom
    src_col = ink_right - rd_row;
    src_row = ink_top + rd_col;
    r.pixel = canvas_mem[(src_row % MAX_H) * MAX_W + (src_col % MAX_W)];
    r.rot_w = icr_pkg::RotWidthW'(bh);
    r.rot_h = icr_pkg::RotHeightW'(bw);
    r.last = (rd_row + 1 == bw) && (rd_col + 1 == bh);
    if (rd_col + 1 >= bh) begin
      rd_col = 0;
      rd_row = (rd_row + 1 >= bw) ? 0 : rd_row + 1;
    end else begin
      rd_col++;
    end
    return r;
  endfunction

  // a read may only touch entries that hold data
  function automatic bit ink_box_loaded();
    if (!ink_seen) return 1'b1;
    for (int unsigned r = ink_top; r <= ink_bottom; r++)
      for (int unsigned c = ink_left; c <= ink_right; c++)
        if (!canvas_written[r * MAX_W + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [icr_pkg::PixelW-1:0] ink_pixel(int unsigned dens);
    return ($urandom_range(99) < dens) ? icr_pkg::PixelW'($urandom_range(1, 65535)) : '0;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic fn, input logic [icr_pkg::PixelW-1:0] px,
                           input logic first);
    gap_pct = (items_sent < ITEM_TARGET / 3) ? 36 :
              (items_sent < 2 * ITEM_TARGET / 3) ? 50 : 0;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      func_i <= 1'($urandom);
      pixel_in_i <= icr_pkg::PixelW'($urandom);
      first_pixel_i <= 1'($urandom);
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= fn;
    pixel_in_i <= px;
    first_pixel_i <= first;
    do @(posedge clk_i); while (busy);
    if (fn == icr_pkg::FUNC_READ) begin
      rotated_q.push_back(rotate_read());
      reads_sent++;
    end else begin
      canvas_load(px, first);
      loads_sent++;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rand_read();
    send_item(icr_pkg::FUNC_READ, icr_pkg::PixelW'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [icr_pkg::CfgIdxW-1:0] idx, input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= icr_pkg::CfgDataW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == icr_pkg::CFG_CANVAS_WIDTH) width_reg = data & 9'h1FF;
    else if (idx == icr_pkg::CFG_CANVAS_HEIGHT) height_reg = data & 7'h7F;
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= icr_pkg::CfgDataW'($urandom);
    @(negedge clk_i);
  endtask

  task automatic set_canvas(input int unsigned wdat, input int unsigned hdat);
    drain_results();
    write_reg(icr_pkg::CFG_CANVAS_WIDTH, wdat);
    write_reg(icr_pkg::CFG_CANVAS_HEIGHT, hdat);
    if ($urandom_range(7) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom_range(511));
  endtask

  task automatic test_directed();
    // read straight after reset sees an empty frame
    send_item(icr_pkg::FUNC_READ, 16'h5A5A, 1'b1);
    set_canvas(3, 2);
    // all-black frame
    for (int k = 0; k < 6; k++) send_item(icr_pkg::FUNC_LOAD, '0, k == 0);
    send_item(icr_pkg::FUNC_READ, '0, 1'b0);
    // ink box 2x2 at the top-left, full readout then wrap to the first pixel
    send_item(icr_pkg::FUNC_LOAD, 16'h0000, 1'b1);
    send_item(icr_pkg::FUNC_LOAD, 16'hFFFF, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h0000, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h0001, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h8000, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h0000, 1'b0);
    for (int k = 0; k < 5; k++) send_item(icr_pkg::FUNC_READ, 16'hA5A5, k[0]);
    // loading past the end of the canvas wraps to row 0 and keeps the box,
    // which grows to the right while readout is halfway
    send_item(icr_pkg::FUNC_LOAD, 16'h0000, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h0000, 1'b0);
    send_item(icr_pkg::FUNC_LOAD, 16'h07E0, 1'b0);
    send_item(icr_pkg::FUNC_READ, 16'hFFFF, 1'b0);
    send_item(icr_pkg::FUNC_READ, 16'h0000, 1'b1);
    frames_sent += 3;
  endtask

  task automatic test_extreme_canvas();
    // out-of-range width acts as the maximum, zero height as one row
    set_canvas(511, 0);
    for (int k = 0; k < MAX_W; k++)
      send_item(icr_pkg::FUNC_LOAD, (k == 0 || k == MAX_W - 1) ?
                icr_pkg::PixelW'($urandom_range(1, 65535)) : ink_pixel(30), k == 0);
    for (int k = 0; k < 12; k++) send_rand_read();
    // zero width acts as one column, out-of-range height as the maximum
    set_canvas(0, 127);
    for (int k = 0; k < MAX_H; k++)
      send_item(icr_pkg::FUNC_LOAD, (k == 0 || k == MAX_H - 1) ?
                icr_pkg::PixelW'($urandom_range(1, 65535)) : ink_pixel(50), k == 0);
    for (int k = 0; k < 12; k++) send_rand_read();
    frames_sent += 2;
  endtask

  task automatic test_random_frames();
    int unsigned wdat, hdat, ew, eh, area, dens, n_ld, n_rd, ba;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0: wdat = $urandom_range(13, 24);
        1: wdat = $urandom_range(1);
        default: wdat = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
        0: hdat = $urandom_range(7, 10);
        1: hdat = $urandom_range(1) ? $urandom_range(1) : $urandom_range(MAX_H, 127);
        default: hdat = $urandom_range(1, 6);
      endcase
      ew = eff_dim(wdat, MAX_W);
      eh = eff_dim(hdat, MAX_H);
      if (ew * eh > 60) begin
        hdat = $urandom_range(1, 60 / ew);
        eh = hdat;
      end
      // upper data bits are dropped by the height register
      if ($urandom_range(9) == 0) hdat |= $urandom_range(1, 3) << 7;
      area = ew * eh;
      dens = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 70);
      set_canvas(wdat, hdat);
      if ($urandom_range(6) != 0) begin
        for (int unsigned k = 0; k < area; k++) begin
          send_item(icr_pkg::FUNC_LOAD, ink_pixel(dens), k == 0);
          if ($urandom_range(99) < 3 && ink_box_loaded())
            send_rand_read();
        end
        ba = ink_seen ? (ink_right - ink_left + 1) * (ink_bottom - ink_top + 1) : 1;
        n_rd = (ba <= 48) ? ba + $urandom_range(ba) : $urandom_range(1, 48);
      end else begin
        // partial frames, restarts in the middle and runs past the canvas end
        n_ld = $urandom_range(1, 2 * area);
        for (int unsigned k = 0; k < n_ld; k++) begin
          send_item(icr_pkg::FUNC_LOAD, ink_pixel(dens),
                    (k == 0 && $urandom_range(1)) || $urandom_range(19) == 0);
          if ($urandom_range(99) < 20 && ink_box_loaded())
            send_rand_read();
        end
        n_rd = ink_box_loaded() ? $urandom_range(0, 6) : 0;
      end
      for (int unsigned k = 0; k < n_rd; k++) send_rand_read();
      frames_sent++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (rotated_q.size() == 0) begin
        fail_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result px=%h w=%0d h=%0d empty=%b last=%b", pixel_out_o,
                   rotated_width_o, rotated_height_o, empty_res_o, out_last_o);
      end else begin
        want_px = rotated_q.pop_front();
        pixels_checked++;
        if (pixel_out_o !== want_px.pixel || rotated_width_o !== want_px.rot_w ||
            rotated_height_o !== want_px.rot_h || empty_res_o !== want_px.empty ||
            out_last_o !== want_px.last) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"mismatch: want px=%h w=%0d h=%0d empty=%b last=%b,",
                      " got px=%h w=%0d h=%0d empty=%b last=%b"},
                     want_px.pixel, want_px.rot_w, want_px.rot_h, want_px.empty,
                     want_px.last, pixel_out_o, rotated_width_o, rotated_height_o,
                     empty_res_o, out_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               rotated_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = icr_pkg::FUNC_LOAD;
    pixel_in_i = '0;
    first_pixel_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = icr_pkg::CFG_CANVAS_WIDTH;
    cfg_data_i = '0;
    width_reg = 32'(icr_pkg::CANVAS_WIDTH_RST);
    height_reg = 32'(icr_pkg::CANVAS_HEIGHT_RST);
    ld_col = 0;
    ld_row = 0;
    rd_row = 0;
    rd_col = 0;
    clear_ink_box();
    gap_pct = 36;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_extreme_canvas();
    test_random_frames();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (rotated_q.size() != 0) fail_cnt += rotated_q.size();
    $display("run covered %0d frames, %0d transfers (%0d loads, %0d reads), %0d reg writes",
             frames_sent, items_sent, loads_sent, reads_sent, reg_writes);
    $display("%0d rotated pixels compared, %0d mismatches", pixels_checked, mismatch_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/icr_pkg.sv
rtl/icr_ram.sv
rtl/icr_ctrl.sv
rtl/icr_datapath.sv
rtl/ink_crop_rotate_ccw.sv
sim/ink_crop_rotate_ccw_tb.sv
